FILE: hw/rtl/lep_pkg.sv
package lep_pkg;

   // Width of a node identifier on both channels
   localparam int NODE_W = 8;

   // Number of distinct node identifiers that fit in NODE_W bits
   localparam int NODE_SPAN = 1 << NODE_W;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_POP,        // take the next queued request
      BK_HEAD,       // read the node at position zero
      BK_HEAD_SEEN,  // look up the last occurrence of the first node
      BK_POS,        // set the walk position, read the node there
      BK_HERE,       // look up the last occurrence of that node
      BK_JUMP,       // clamp the jump, read the node at the jump target
      BK_OUT         // hand the kept node to the output register
   } bk_state_type;

endpackage

FILE: hw/rtl/lep_queue.sv
module lep_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/lep_front.sv
module lep_front #(
   parameter int MAX_PATH = 64,
   parameter int POS_W    = 6,
   parameter int LEN_W    = 7,
   parameter int ENTRY_W  = 3 + LEN_W + POS_W + lep_pkg::NODE_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [lep_pkg::NODE_W-1:0] req_step_node,
   input  logic                      req_path_end,
   input  logic                      q_full,
   output logic                      q_push,
   output logic [ENTRY_W-1:0]        q_data
);

   logic [LEN_W-1:0] length_ff;
   logic [LEN_W-1:0] length_in;
   logic             overflow_ff;
   logic             overflow_in;
   logic             room;
   logic [LEN_W-1:0] op_len;
   logic             op_ovf;

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full;

   // Classify the request: store it at the next position or drop it
   always_comb begin
      room   = (length_ff < LEN_W'(MAX_PATH));
      op_len = room ? length_ff + LEN_W'(1) : length_ff;
      op_ovf = overflow_ff | ~room;
      q_data = {req_path_end, room, op_ovf, op_len, length_ff[POS_W-1:0], req_step_node};
   end

   // Advance the path counters, restart them after the final step
   always_comb begin
      length_in   = length_ff;
      overflow_in = overflow_ff;
      if (q_push) begin
         if (req_path_end) begin
            length_in   = '0;
            overflow_in = 1'b0;
         end else begin
            length_in   = op_len;
            overflow_in = op_ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         overflow_ff <= 1'b0;
      end else begin
         length_ff   <= length_in;
         overflow_ff <= overflow_in;
      end
   end

endmodule

FILE: hw/rtl/lep_back.sv
module lep_back #(
   parameter int MAX_PATH   = 64,
   parameter int NODE_COUNT = 256,
   parameter int POS_W      = 6,
   parameter int LEN_W      = 7,
   parameter int ENTRY_W    = 3 + LEN_W + POS_W + lep_pkg::NODE_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_empty,
   input  logic [ENTRY_W-1:0]         q_data,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lep_pkg::NODE_W-1:0] rsp_kept_node,
   output logic                       rsp_route_end,
   output logic                       rsp_path_overflow
);

   localparam int SLOT_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

   // Unpacked queue entry
   logic                       e_last;
   logic                       e_wr;
   logic                       e_ovf;
   logic [LEN_W-1:0]           e_len;
   logic [POS_W-1:0]           e_pos;
   logic [lep_pkg::NODE_W-1:0] e_node;

   // Storage
   logic [lep_pkg::NODE_W-1:0] path_store_ff [MAX_PATH];
   logic [POS_W-1:0]           last_seen_ff [NODE_COUNT];
   logic [lep_pkg::NODE_W-1:0] st_rd_ff;
   logic [POS_W-1:0]           seen_rd_ff;
   logic [SLOT_W-1:0]          slot_tab [lep_pkg::NODE_SPAN];

   // Sequencer
   lep_pkg::bk_state_type      state_ff;
   lep_pkg::bk_state_type      state_in;
   logic [POS_W-1:0]           pos_ff;
   logic [POS_W-1:0]           pos_in;
   logic [POS_W-1:0]           jump_ff;
   logic [POS_W-1:0]           jump_in;
   logic [LEN_W-1:0]           len_ff;
   logic [LEN_W-1:0]           len_in;
   logic                       ovf_ff;
   logic                       ovf_in;

   logic                       mem_wr;
   logic                       st_rd_en;
   logic [POS_W-1:0]           st_rd_addr;
   logic                       seen_rd_en;
   logic [SLOT_W-1:0]          seen_rd_addr;
   logic [POS_W-1:0]           jump_sel;
   logic                       route_last;
   logic [POS_W-1:0]           next_pos;
   logic                       out_free;
   logic                       out_load;

   // Output register
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [lep_pkg::NODE_W-1:0] kept_node_ff;
   logic                       route_end_ff;
   logic                       path_overflow_ff;

   assign {e_last, e_wr, e_ovf, e_len, e_pos, e_node} = q_data;

   // Fold node identifiers onto table slots
   for (genvar g = 0; g < lep_pkg::NODE_SPAN; g++) begin : g_slot
      assign slot_tab[g] = SLOT_W'(g % NODE_COUNT);
   end

   // Walk bookkeeping
   always_comb begin
      jump_sel = ((seen_rd_ff < pos_ff) || (LEN_W'(seen_rd_ff) >= len_ff)) ?
                 pos_ff : seen_rd_ff;
      route_last = ((LEN_W'(jump_ff) + LEN_W'(1)) >= len_ff);
      next_pos   = jump_ff + POS_W'(1);
      out_free   = ~rsp_valid_ff | ~rsp_stall;
   end

   // Next state and memory controls
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      jump_in      = jump_ff;
      len_in       = len_ff;
      ovf_in       = ovf_ff;
      q_pop        = 1'b0;
      mem_wr       = 1'b0;
      st_rd_en     = 1'b0;
      st_rd_addr   = pos_ff;
      seen_rd_en   = 1'b0;
      seen_rd_addr = slot_tab[st_rd_ff];
      out_load     = 1'b0;
      case (state_ff)
         lep_pkg::BK_POP: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               mem_wr = e_wr;
               if (e_last) begin
                  len_in   = e_len;
                  ovf_in   = e_ovf;
                  state_in = lep_pkg::BK_HEAD;
               end
            end
         end
         lep_pkg::BK_HEAD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = '0;
            state_in   = lep_pkg::BK_HEAD_SEEN;
         end
         lep_pkg::BK_HEAD_SEEN: begin
            seen_rd_en = 1'b1;
            state_in   = lep_pkg::BK_POS;
         end
         lep_pkg::BK_POS: begin
            pos_in     = seen_rd_ff;
            st_rd_en   = 1'b1;
            st_rd_addr = seen_rd_ff;
            state_in   = lep_pkg::BK_HERE;
         end
         lep_pkg::BK_HERE: begin
            seen_rd_en = 1'b1;
            state_in   = lep_pkg::BK_JUMP;
         end
         lep_pkg::BK_JUMP: begin
            jump_in    = jump_sel;
            st_rd_en   = 1'b1;
            st_rd_addr = jump_sel;
            state_in   = lep_pkg::BK_OUT;
         end
         lep_pkg::BK_OUT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (route_last) begin
                  state_in = lep_pkg::BK_POP;
               end else begin
                  pos_in     = next_pos;
                  st_rd_en   = 1'b1;
                  st_rd_addr = next_pos;
                  state_in   = lep_pkg::BK_HERE;
               end
            end
         end
         default: begin
            state_in = lep_pkg::BK_POP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lep_pkg::BK_POP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      jump_ff <= jump_in;
      len_ff  <= len_in;
      ovf_ff  <= ovf_in;
   end

   // Path store and last-occurrence table: one write, one registered read each
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         path_store_ff[e_pos]          <= e_node;
         last_seen_ff[slot_tab[e_node]] <= e_pos;
      end
      if (st_rd_en) begin
         st_rd_ff <= path_store_ff[st_rd_addr];
      end
      if (seen_rd_en) begin
         seen_rd_ff <= last_seen_ff[seen_rd_addr];
      end
   end

   // Hold the result until the receiver takes it
   always_comb begin
      rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         kept_node_ff     <= st_rd_ff;
         route_end_ff     <= route_last;
         path_overflow_ff <= ovf_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kept_node     = kept_node_ff;
   assign rsp_route_end     = route_end_ff;
   assign rsp_path_overflow = path_overflow_ff;

   // Never overwrite a result that is still stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // The queue is drained only between emissions
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == lep_pkg::BK_POP))
      else $error("queue popped during emission");

   // A kept position always lies inside the stored path
   a_jump_range: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (LEN_W'(jump_ff) < len_ff))
      else $error("kept position beyond path length");

   // The last kept node returns the sequencer to the queue
   a_end_return: assert property (@(posedge clock) disable iff (reset)
      (out_load && route_last) |=> (state_ff == lep_pkg::BK_POP && rsp_route_end))
      else $error("sequencer did not return after route end");

endmodule

FILE: hw/rtl/loop_erased_path.sv
// Loop erasure of a walked node path.
//
// Input channel (req_*): one walk step per request, req_step_node the node
// and req_path_end set on the final step. Steps are taken one per cycle while
// the two-entry request queue has room; req_stall rises when it is full.
// Steps beyond MAX_PATH are dropped and reported on every result of the path.
// Result channel (rsp_*): after the final step the loop-erased path comes out
// one kept node per result, rsp_route_end set on the last one.
// The final step reaches the back end after queued steps drain (one per
// cycle in BK_POP); the first result walks states HEAD through OUT, each
// later one HERE, JUMP and OUT, paced by the dependent reads path store ->
// last-seen table -> path store, each with a registered read port.
// Steps of the next path are accepted while results are still being sent,
// until the queue fills.
// A stalled result stays in the output register; the sequencer waits on it.
// Reset clears the counters, the queue and the output valid; the stores need
// no clearing, since emission reads only entries written for the current path.
module loop_erased_path #(
   parameter int MAX_PATH   = 64,
   parameter int NODE_COUNT = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lep_pkg::NODE_W-1:0] req_step_node,
   input  logic                       req_path_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lep_pkg::NODE_W-1:0] rsp_kept_node,
   output logic                       rsp_route_end,
   output logic                       rsp_path_overflow
);

   localparam int POS_W   = $clog2(MAX_PATH);
   localparam int LEN_W   = $clog2(MAX_PATH + 1);
   localparam int ENTRY_W = 3 + LEN_W + POS_W + lep_pkg::NODE_W;

   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   logic [ENTRY_W-1:0] q_push_data;
   logic [ENTRY_W-1:0] q_pop_data;

   lep_front #(
      .MAX_PATH (MAX_PATH),
      .POS_W    (POS_W),
      .LEN_W    (LEN_W),
      .ENTRY_W  (ENTRY_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_step_node (req_step_node),
      .req_path_end  (req_path_end),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_push_data)
   );

   lep_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   lep_back #(
      .MAX_PATH   (MAX_PATH),
      .NODE_COUNT (NODE_COUNT),
      .POS_W      (POS_W),
      .LEN_W      (LEN_W),
      .ENTRY_W    (ENTRY_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_data            (q_pop_data),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kept_node     (rsp_kept_node),
      .rsp_route_end     (rsp_route_end),
      .rsp_path_overflow (rsp_path_overflow)
   );

endmodule
